// ===== rtl/core/i2c_bit_level_master_macros.svh =====
// ---------------------------------------------------------------------------
// I2C bit-level master assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// same-cycle implication
`define I2CBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/i2cbl_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C bit-level master package
// Widths, operation and phase codes, and the word and state types.
// ---------------------------------------------------------------------------
package i2cbl_pkg;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int PHASE_W   = 2;
    localparam int BITCNT_W  = 4;
    localparam int BYTE_BITS = 8;

    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd250;

    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_NACK  = 3'd5;
    localparam logic [OP_W-1:0] OP_WAIT  = 3'd6;

    localparam logic [PHASE_W-1:0] PH_SETUP = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HIGH  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LOW   = 2'd2;

    typedef struct packed {
        logic              accept;
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] tx_byte;
        logic              sda_line;
    } tick_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_received;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [PHASE_W-1:0]  phase;
        logic [BITCNT_W-1:0] bit_count;
        logic [BYTE_W-1:0]   shift;
        logic [BYTE_W-1:0]   poll_count;
        logic                scl;
        logic                sda;
        logic                in_timeout_stop;
        logic                busy;
        logic                ack;
        logic [BYTE_W-1:0]   rx_hold;
    } state_t;

endpackage

// ===== rtl/core/i2cbl_if.sv =====
// ---------------------------------------------------------------------------
// I2C bit-level master channels
// Valid/ready interfaces for the tick word and the result word.
// ---------------------------------------------------------------------------
interface i2cbl_tick_if;
    logic                         valid;
    logic                         ready;
    logic                         accept;
    logic [i2cbl_pkg::OP_W-1:0]   operation;
    logic [i2cbl_pkg::BYTE_W-1:0] tx_byte;
    logic                         sda_line;

    modport source (output valid, accept, operation, tx_byte, sda_line, input ready);
    modport sink   (input valid, accept, operation, tx_byte, sda_line, output ready);
endinterface

interface i2cbl_result_if;
    logic                         valid;
    logic                         ready;
    logic                         scl_level;
    logic                         sda_release;
    logic                         busy_res;
    logic                         done_res;
    logic [i2cbl_pkg::BYTE_W-1:0] rx_byte;
    logic                         ack_received;

    modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    ack_received, input ready);
    modport sink   (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                    ack_received, output ready);
endinterface

// ===== rtl/core/i2cbl_step.sv =====
// ---------------------------------------------------------------------------
// I2C bit-level master tick step
// Next-state and line drive for one timing tick of the current primitive.
// ---------------------------------------------------------------------------
module i2cbl_step
(
    input  i2cbl_pkg::state_t           cur,
    input  i2cbl_pkg::tick_t            item,
    input  logic [i2cbl_pkg::BYTE_W-1:0] limit,
    output i2cbl_pkg::state_t           nxt,
    output i2cbl_pkg::result_t          res
);

    i2cbl_pkg::state_t st;
    logic              done;
    logic              release_after;
    logic              busy_out;

    always_comb
    begin
        st            = cur;
        done          = 1'b0;
        release_after = 1'b0;
        busy_out      = 1'b0;

        if (!st.busy && item.accept && item.operation <= i2cbl_pkg::OP_WAIT)
        begin
            st.busy            = 1'b1;
            st.op              = item.operation;
            st.phase           = i2cbl_pkg::PH_SETUP;
            st.bit_count       = '0;
            st.poll_count      = '0;
            st.in_timeout_stop = 1'b0;
            st.shift           = (item.operation == i2cbl_pkg::OP_SEND) ? item.tx_byte : '0;
        end

        if (st.busy)
        begin
            busy_out = 1'b1;
            unique case (st.op)
                i2cbl_pkg::OP_START:
                begin
                    if (st.phase == i2cbl_pkg::PH_SETUP)
                    begin
                        st.sda = 1'b1;
                        st.scl = 1'b1;
                    end
                    else if (st.phase == i2cbl_pkg::PH_HIGH)
                        st.sda = 1'b0;
                    else
                    begin
                        st.scl = 1'b0;
                        done   = 1'b1;
                    end
                    st.phase = st.phase + 2'd1;
                end
                i2cbl_pkg::OP_STOP:
                begin
                    if (st.phase == i2cbl_pkg::PH_SETUP)
                        st.sda = 1'b0;
                    else if (st.phase == i2cbl_pkg::PH_HIGH)
                        st.scl = 1'b1;
                    else
                    begin
                        st.sda = 1'b1;
                        done   = 1'b1;
                    end
                    st.phase = st.phase + 2'd1;
                end
                i2cbl_pkg::OP_SEND, i2cbl_pkg::OP_READ:
                begin
                    if (st.phase == i2cbl_pkg::PH_SETUP)
                    begin
                        if (st.op == i2cbl_pkg::OP_SEND)
                        begin
                            st.sda   = st.shift[i2cbl_pkg::BYTE_W-1];
                            st.shift = {st.shift[i2cbl_pkg::BYTE_W-2:0], 1'b0};
                        end
                        else
                        begin
                            st.sda = 1'b1;
                            st.scl = 1'b1;
                        end
                        st.phase = i2cbl_pkg::PH_HIGH;
                    end
                    else if (st.phase == i2cbl_pkg::PH_HIGH)
                    begin
                        if (st.op == i2cbl_pkg::OP_SEND)
                            st.scl = 1'b1;
                        else
                            st.shift = {st.shift[i2cbl_pkg::BYTE_W-2:0], item.sda_line};
                        st.phase = i2cbl_pkg::PH_LOW;
                    end
                    else
                    begin
                        st.scl       = 1'b0;
                        st.bit_count = st.bit_count + 4'd1;
                        st.phase     = i2cbl_pkg::PH_SETUP;
                        if (st.bit_count >= 4'(i2cbl_pkg::BYTE_BITS))
                        begin
                            done = 1'b1;
                            if (st.op == i2cbl_pkg::OP_READ)
                                st.rx_hold = st.shift;
                        end
                    end
                end
                i2cbl_pkg::OP_ACK, i2cbl_pkg::OP_NACK:
                begin
                    if (st.phase == i2cbl_pkg::PH_SETUP)
                        st.sda = (st.op == i2cbl_pkg::OP_NACK);
                    else if (st.phase == i2cbl_pkg::PH_HIGH)
                        st.scl = 1'b1;
                    else
                    begin
                        st.scl        = 1'b0;
                        done          = 1'b1;
                        release_after = (st.op == i2cbl_pkg::OP_ACK);
                    end
                    st.phase = st.phase + 2'd1;
                end
                i2cbl_pkg::OP_WAIT:
                begin
                    if (st.in_timeout_stop)
                    begin
                        if (st.phase == i2cbl_pkg::PH_SETUP)
                            st.sda = 1'b0;
                        else if (st.phase == i2cbl_pkg::PH_HIGH)
                            st.scl = 1'b1;
                        else
                        begin
                            st.sda = 1'b1;
                            st.ack = 1'b0;
                            done   = 1'b1;
                        end
                        st.phase = st.phase + 2'd1;
                    end
                    else if (st.phase == i2cbl_pkg::PH_SETUP)
                    begin
                        st.sda   = 1'b1;
                        st.phase = i2cbl_pkg::PH_HIGH;
                    end
                    else if (st.phase == i2cbl_pkg::PH_HIGH)
                    begin
                        st.scl   = 1'b1;
                        st.phase = i2cbl_pkg::PH_LOW;
                    end
                    else if (!item.sda_line)
                    begin
                        st.scl = 1'b0;
                        st.ack = 1'b1;
                        done   = 1'b1;
                    end
                    else if (st.poll_count >= limit)
                    begin
                        st.in_timeout_stop = 1'b1;
                        st.sda             = 1'b0;
                        st.phase           = i2cbl_pkg::PH_HIGH;
                    end
                    else
                        st.poll_count = st.poll_count + 8'd1;
                end
                default:
                begin
                    busy_out = 1'b1;
                end
            endcase
        end

        res.scl_level    = st.scl;
        res.sda_release  = st.sda;
        res.busy_res     = busy_out;
        res.done_res     = done;
        res.rx_byte      = st.rx_hold;
        res.ack_received = st.ack;

        if (done)
        begin
            st.busy            = 1'b0;
            st.phase           = i2cbl_pkg::PH_SETUP;
            st.bit_count       = '0;
            st.in_timeout_stop = 1'b0;
            if (release_after)
                st.sda = 1'b1;
        end

        nxt = st;
    end

endmodule

// ===== rtl/core/i2c_bit_level_master.sv =====
// ---------------------------------------------------------------------------
// I2C bit-level master
// Tick-driven master that runs start, stop, byte and acknowledge primitives.
// ---------------------------------------------------------------------------
// Each word on tick is one bus timing tick: a command request (accept,
// operation, tx_byte) and the sampled data line. Every tick word yields
// exactly one word on result: clock and data drive after that tick, busy,
// done, the last read byte and the last wait-ack outcome.
// Throughput: one tick per cycle while result.ready stays high. A tick word is
// registered in the tick register, stepped, and registered again in the result
// register; the step is one pass of logic between the tick register and the
// result register.
// cfg_write_en loads the timeout limit (limit_reg) from cfg_write_data;
// write it only while no tick is in flight.
// Reset: bus lines released high, no primitive in progress, limit 250,
// read byte and acknowledge flag cleared.
// When the receiver stalls, the result register holds, the tick register
// fills, and tick.ready drops until the result word is taken.
// ---------------------------------------------------------------------------
`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master
(
    input  logic                         clk,
    input  logic                         rst_n,
    i2cbl_tick_if.sink                   tick,
    i2cbl_result_if.source               result,
    input  logic                         cfg_write_en,
    input  logic [i2cbl_pkg::BYTE_W-1:0] cfg_write_data
);

    logic                         in_valid_reg;
    i2cbl_pkg::tick_t             in_data_reg;
    logic                         out_valid_reg;
    i2cbl_pkg::result_t           out_data_reg;
    i2cbl_pkg::state_t            state_reg;
    i2cbl_pkg::state_t            state_next;
    i2cbl_pkg::result_t           step_res;
    logic [i2cbl_pkg::BYTE_W-1:0] limit_reg;
    logic                         fire;

    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || fire;

    i2cbl_step u_step
    (
        .cur   (state_reg),
        .item  (in_data_reg),
        .limit (limit_reg),
        .nxt   (state_next),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= i2cbl_pkg::LIMIT_RESET;
            state_reg     <= '{op: i2cbl_pkg::OP_START, phase: i2cbl_pkg::PH_SETUP,
                               bit_count: '0, shift: '0, poll_count: '0, scl: 1'b1,
                               sda: 1'b1, in_timeout_stop: 1'b0, busy: 1'b0,
                               ack: 1'b0, rx_hold: '0};
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg_write_en)
                limit_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_data_reg.accept    <= tick.accept;
            in_data_reg.operation <= tick.operation;
            in_data_reg.tx_byte   <= tick.tx_byte;
            in_data_reg.sda_line  <= tick.sda_line;
        end
        if (fire)
            out_data_reg <= step_res;
    end

    assign result.valid        = out_valid_reg;
    assign result.scl_level    = out_data_reg.scl_level;
    assign result.sda_release  = out_data_reg.sda_release;
    assign result.busy_res     = out_data_reg.busy_res;
    assign result.done_res     = out_data_reg.done_res;
    assign result.rx_byte      = out_data_reg.rx_byte;
    assign result.ack_received = out_data_reg.ack_received;

    `I2CBL_ASSERT_NOW(a_idle_clean, !state_reg.busy,
        state_reg.phase == i2cbl_pkg::PH_SETUP && state_reg.bit_count == '0 &&
        !state_reg.in_timeout_stop, "idle state not cleared")
    `I2CBL_ASSERT_NEXT(a_done_frees, fire && step_res.done_res, !state_reg.busy,
        "primitive still busy after done")
    `I2CBL_ASSERT_NOW(a_timeout_wait, state_reg.in_timeout_stop,
        state_reg.busy && state_reg.op == i2cbl_pkg::OP_WAIT, "timeout stop outside wait-ack")
    `I2CBL_ASSERT_NOW(a_bitcnt_range, 1'b1,
        state_reg.bit_count < 4'(i2cbl_pkg::BYTE_BITS), "bit count past byte")
    `I2CBL_ASSERT_NOW(a_phase_range, 1'b1, state_reg.phase <= i2cbl_pkg::PH_LOW,
        "phase out of range")

endmodule

// ===== test/i2c_bit_level_master_tb.sv =====
// ---------------------------------------------------------------------------
// I2C bit-level master testbench
// Drives bus ticks through the tick channel and checks every result word
// against a tick-by-tick model of the primitives or a typed directed row. A
// short directed table covers reset, the unused operation code, a command
// while busy and every primitive but read. Random ticks follow, under several
// timeout limits including zero and 255, with random stalls on both channels.
// ---------------------------------------------------------------------------
module i2c_bit_level_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbl_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE     = 3'd7;
    localparam int              CYCLE_LIMIT = 400000;

    localparam result_t UNTYPED     = '0;
    localparam result_t LINES_IDLE  = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam result_t START_SETUP = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam result_t START_FALL  = {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam result_t START_DONE  = {1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0};

    typedef struct packed {
        tick_t   t;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic [BYTE_W-1:0] cfg_write_data;

    i2cbl_tick_if   tick_ch();
    i2cbl_result_if result_ch();

    i2c_bit_level_master DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick_ch),
        .result         (result_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // bus model state
    logic [OP_W-1:0]     bus_op       = OP_START;
    logic [PHASE_W-1:0]  bus_phase    = PH_SETUP;
    logic [BITCNT_W-1:0] bit_cnt      = '0;
    logic [BYTE_W-1:0]   shifter      = '0;
    logic [BYTE_W-1:0]   polls        = '0;
    logic                scl_q        = 1'b1;
    logic                sda_q        = 1'b1;
    logic                timeout_stop = 1'b0;
    logic                busy_q       = 1'b0;
    logic                ack_q        = 1'b0;
    logic [BYTE_W-1:0]   rx_q         = '0;
    logic [BYTE_W-1:0]   ack_limit    = LIMIT_RESET;

    result_t   expected_bus[$];
    stim_row_t directed_rows[$];
    int        mismatches  = 0;
    int        hold_cycles = 0;
    bit        tx_idle_on  = 1'b1;
    bit        rx_idle_on  = 1'b1;
    int        cycles      = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit stop_step(input logic [PHASE_W-1:0] ph);
        if (ph == PH_SETUP)
        begin
            sda_q = 1'b0;
            return 1'b0;
        end
        if (ph == PH_HIGH)
        begin
            scl_q = 1'b1;
            return 1'b0;
        end
        sda_q = 1'b1;
        return 1'b1;
    endfunction

    function automatic result_t advance_bus(input tick_t t);
        result_t        r;
        logic           fin;
        logic           release_sda;
        logic [BYTE_W:0] next_poll;
        fin = 1'b0;
        release_sda = 1'b0;
        r = '0;
        if (!busy_q && t.accept && t.operation <= OP_WAIT)
        begin
            busy_q = 1'b1;
            bus_op = t.operation;
            bus_phase = PH_SETUP;
            bit_cnt = '0;
            polls = '0;
            timeout_stop = 1'b0;
            shifter = (t.operation == OP_SEND) ? t.tx_byte : '0;
        end
        r.busy_res = busy_q;
        if (busy_q)
        begin
            case (bus_op)
                OP_START:
                begin
                    if (bus_phase == PH_SETUP)
                    begin
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                    end
                    else if (bus_phase == PH_HIGH)
                        sda_q = 1'b0;
                    else
                    begin
                        scl_q = 1'b0;
                        fin = 1'b1;
                    end
                    bus_phase = bus_phase + 1'b1;
                end
                OP_STOP:
                begin
                    fin = stop_step(bus_phase);
                    bus_phase = bus_phase + 1'b1;
                end
                OP_SEND, OP_READ:
                begin
                    if (bus_phase == PH_SETUP)
                    begin
                        if (bus_op == OP_SEND)
                        begin
                            sda_q = shifter[BYTE_W-1];
                            shifter = shifter << 1;
                        end
                        else
                        begin
                            sda_q = 1'b1;
                            scl_q = 1'b1;
                        end
                        bus_phase = PH_HIGH;
                    end
                    else if (bus_phase == PH_HIGH)
                    begin
                        if (bus_op == OP_SEND)
                            scl_q = 1'b1;
                        else
                            shifter = {shifter[BYTE_W-2:0], t.sda_line};
                        bus_phase = PH_LOW;
                    end
                    else
                    begin
                        scl_q = 1'b0;
                        bit_cnt = bit_cnt + 1'b1;
                        bus_phase = PH_SETUP;
                        if (bit_cnt >= BYTE_BITS)
                        begin
                            fin = 1'b1;
                            if (bus_op == OP_READ)
                                rx_q = shifter;
                        end
                    end
                end
                OP_ACK, OP_NACK:
                begin
                    if (bus_phase == PH_SETUP)
                        sda_q = (bus_op == OP_NACK);
                    else if (bus_phase == PH_HIGH)
                        scl_q = 1'b1;
                    else
                    begin
                        scl_q = 1'b0;
                        fin = 1'b1;
                        release_sda = (bus_op == OP_ACK);
                    end
                    bus_phase = bus_phase + 1'b1;
                end
                default:
                begin
                    if (timeout_stop)
                    begin
                        fin = stop_step(bus_phase);
                        bus_phase = bus_phase + 1'b1;
                        if (fin)
                            ack_q = 1'b0;
                    end
                    else if (bus_phase == PH_SETUP)
                    begin
                        sda_q = 1'b1;
                        bus_phase = PH_HIGH;
                    end
                    else if (bus_phase == PH_HIGH)
                    begin
                        scl_q = 1'b1;
                        bus_phase = PH_LOW;
                    end
                    else if (!t.sda_line)
                    begin
                        scl_q = 1'b0;
                        ack_q = 1'b1;
                        fin = 1'b1;
                    end
                    else
                    begin
                        next_poll = {1'b0, polls} + 1'b1;
                        if (next_poll > {1'b0, ack_limit})
                        begin
                            timeout_stop = 1'b1;
                            void'(stop_step(PH_SETUP));
                            bus_phase = PH_HIGH;
                        end
                        else
                            polls = next_poll[BYTE_W-1:0];
                    end
                end
            endcase
        end
        r.scl_level = scl_q;
        r.sda_release = sda_q;
        r.done_res = fin;
        r.rx_byte = rx_q;
        r.ack_received = ack_q;
        if (fin)
        begin
            busy_q = 1'b0;
            bus_phase = PH_SETUP;
            bit_cnt = '0;
            timeout_stop = 1'b0;
            if (release_sda)
                sda_q = 1'b1;
        end
        return r;
    endfunction

    task automatic put_tick(input tick_t t, input logic typed, input result_t want);
        int      gap;
        result_t r;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.accept    <= t.accept;
        tick_ch.operation <= t.operation;
        tick_ch.tx_byte   <= t.tx_byte;
        tick_ch.sda_line  <= t.sda_line;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        r = advance_bus(t);
        expected_bus.push_back(typed ? want : r);
    endtask

    task automatic settle_bus();
        while (busy_q)
            put_tick({1'b0, OP_START, 8'h00, 1'b0}, 1'b0, UNTYPED);
        tick_ch.valid <= 1'b0;
        while (expected_bus.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_ticks(input int count);
        tick_t       t;
        logic [31:0] rnd;
        int          since_cmd;
        int          wait_polls;
        int          timeouts_left;
        bit          never;
        bit          cmd_wait;
        since_cmd = 0;
        wait_polls = 0;
        never = 1'b0;
        cmd_wait = 1'b0;
        timeouts_left = (ack_limit < 12) ? 20 : 1;
        for (int i = 0; i < count; i++)
        begin
            rnd = $urandom;
            t.tx_byte = rnd[7:0];
            if (!busy_q)
            begin
                t.accept = (rnd[10:8] != 3'd0);
                t.operation = (rnd[15:12] == 4'd0) ? OP_NONE : 3'($urandom_range(0, 6));
                cmd_wait = t.accept && (t.operation == OP_WAIT);
                since_cmd = 0;
                if (cmd_wait)
                begin
                    wait_polls = (ack_limit < 12) ? $urandom_range(0, ack_limit + 1)
                                                  : $urandom_range(0, 6);
                    never = (timeouts_left > 0) && ($urandom_range(0, 3) == 0);
                    if (never)
                        timeouts_left--;
                end
            end
            else
            begin
                t.accept = (rnd[10:8] == 3'd0);
                t.operation = rnd[18:16];
            end
            if (cmd_wait)
                t.sda_line = never || (since_cmd < 2 + wait_polls);
            else
                t.sda_line = rnd[20];
            put_tick(t, 1'b0, UNTYPED);
            since_cmd++;
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        int      gap;
        result_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (expected_bus.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word with none expected, scl %0b sda %0b",
                         $time, result_ch.scl_level, result_ch.sda_release);
            end
            else
            begin
                want = expected_bus.pop_front();
                report_field("scl_level", {7'd0, want.scl_level},
                             {7'd0, result_ch.scl_level});
                report_field("sda_release", {7'd0, want.sda_release},
                             {7'd0, result_ch.sda_release});
                report_field("busy_res", {7'd0, want.busy_res},
                             {7'd0, result_ch.busy_res});
                report_field("done_res", {7'd0, want.done_res},
                             {7'd0, result_ch.done_res});
                report_field("rx_byte", want.rx_byte, result_ch.rx_byte);
                report_field("ack_received", {7'd0, want.ack_received},
                             {7'd0, result_ch.ack_received});
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] limits[5];
        rst_n             <= 1'b0;
        cfg_write_en      <= 1'b0;
        cfg_write_data    <= '0;
        tick_ch.valid     <= 1'b0;
        tick_ch.accept    <= 1'b0;
        tick_ch.operation <= OP_START;
        tick_ch.tx_byte   <= '0;
        tick_ch.sda_line  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //                       accept operation tx_byte sda   typed  result
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b1, LINES_IDLE});
        directed_rows.push_back({1'b1, OP_NONE,  8'hFF, 1'b1, 1'b1, LINES_IDLE});
        directed_rows.push_back({1'b1, OP_START, 8'h00, 1'b1, 1'b1, START_SETUP});
        directed_rows.push_back({1'b1, OP_STOP,  8'hFF, 1'b0, 1'b1, START_FALL});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b1, START_DONE});
        directed_rows.push_back({1'b1, OP_NACK,  8'h55, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b1, OP_ACK,   8'hAA, 1'b0, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b0, UNTYPED});
        directed_rows.push_back({1'b1, OP_SEND,  8'hFF, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b1, OP_WAIT,  8'h00, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b0, UNTYPED});
        directed_rows.push_back({1'b1, OP_STOP,  8'h00, 1'b0, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b1, 1'b0, UNTYPED});
        directed_rows.push_back({1'b0, OP_START, 8'h00, 1'b0, 1'b0, UNTYPED});
        foreach (directed_rows[i])
            put_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);

        limits[0] = 8'd0;
        limits[1] = 8'd255;
        limits[2] = 8'd1;
        limits[3] = 8'($urandom_range(2, 9));
        limits[4] = 8'd250;
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                settle_bus();
                cfg_write_en   <= 1'b1;
                cfg_write_data <= limits[p-1];
                @(posedge clk);
                cfg_write_en <= 1'b0;
                ack_limit = limits[p-1];
                @(posedge clk);
            end
            tx_idle_on = (p != 2) && (p != 4);
            rx_idle_on = (p != 3) && (p != 4);
            // hold the result side while ticks keep coming
            if (p == 2)
                hold_cycles = 300;
            random_ticks(270);
        end
        settle_bus();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/i2cbl_pkg.sv
rtl/core/i2cbl_if.sv
rtl/core/i2cbl_step.sv
rtl/core/i2c_bit_level_master.sv
test/i2c_bit_level_master_tb.sv
